[hw/rtl/acb_iir_pkg.sv]
`default_nettype none

package acb_iir_pkg;

    // Field and datapath widths.
    localparam int RAW_W      = 16;
    localparam int FIELD_W    = 16;
    localparam int VAL_W      = 20;
    localparam int OPA_W      = 24;
    localparam int OPB_W      = 16;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int FB_W       = 32;

    // Rounding points of the two fixed-point stages.
    localparam int CAL_SHIFT = 8;
    localparam int FLT_SHIFT = 14;

    // Saturation limits of a stored or filtered value.
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_COL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_COL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_COL_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSETS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_COEFFS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_COEFFS   = 3'd5;

    // Configuration register values after reset.
    localparam logic [CFG_DATA_W-1:0] RST_CAL_COL_X   = 48'd1049;
    localparam logic [CFG_DATA_W-1:0] RST_CAL_COL_Y   = 48'd68747264;
    localparam logic [CFG_DATA_W-1:0] RST_CAL_COL_Z   = 48'd4505420693504;
    localparam logic [CFG_DATA_W-1:0] RST_CAL_OFFSETS = 48'd281251636314122;
    localparam logic [CFG_DATA_W-1:0] RST_FF_COEFFS   = 48'd15805961866848;
    localparam logic [FB_W-1:0]       RST_FB_COEFFS   = 32'd278915811;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Product terms of the calibration sum.
    localparam logic [2:0] TRM_RAW_X = 3'd0;
    localparam logic [2:0] TRM_RAW_Y = 3'd1;
    localparam logic [2:0] TRM_RAW_Z = 3'd2;

    // Product terms of the biquad sum.
    localparam logic [2:0] TRM_X0 = 3'd0;
    localparam logic [2:0] TRM_X1 = 3'd1;
    localparam logic [2:0] TRM_X2 = 3'd2;
    localparam logic [2:0] TRM_Y1 = 3'd3;
    localparam logic [2:0] TRM_Y2 = 3'd4;

    localparam logic [2:0] CAL_LAST_TERM = TRM_RAW_Z;
    localparam logic [2:0] FLT_LAST_TERM = TRM_Y2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_MAC,
        ST_CAL_DRAIN,
        ST_CAL_SAT,
        ST_FLT_READ,
        ST_FLT_MAC,
        ST_FLT_DRAIN,
        ST_FLT_SAT,
        ST_EMIT
    } acb_state_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic       mac_en;
        logic       mac_first;
        logic       cal_mode;
        logic       cal_write;
        logic       flt_read;
        logic       flt_first;
        logic       flt_update;
        logic       flt_last;
        logic       emit;
        logic [1:0] axis;
        logic [2:0] term;
    } acb_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/acb_iir_ram.sv]
`default_nettype none

module acb_iir_ram #(
    parameter int WIDTH  = 20,
    parameter int DEPTH  = 12,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/acb_iir_mac.sv]
`default_nettype none

module acb_iir_mac (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire acb_iir_pkg::acb_ctrl_t                  ctrl,
    input  wire logic signed [acb_iir_pkg::OPA_W-1:0]    op_a,
    input  wire logic signed [acb_iir_pkg::OPB_W-1:0]    op_b,
    input  wire logic signed [acb_iir_pkg::VAL_W-1:0]    offset,
    output logic      signed [acb_iir_pkg::VAL_W-1:0]    result
);

    localparam int ACC_W = acb_iir_pkg::ACC_W;

    localparam logic signed [ACC_W-1:0] CAL_HALF = ACC_W'(1) << (acb_iir_pkg::CAL_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] FLT_HALF = ACC_W'(1) << (acb_iir_pkg::FLT_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(acb_iir_pkg::VAL_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(acb_iir_pkg::VAL_MIN);

    logic signed [acb_iir_pkg::PROD_W-1:0] prod_reg;
    logic                                  prod_vld_reg;
    logic                                  first_d_reg;
    logic signed [ACC_W-1:0]               acc_reg;
    logic signed [ACC_W-1:0]               rnd_sum;
    logic signed [ACC_W-1:0]               shifted;
    logic signed [ACC_W-1:0]               with_off;

    // Multiplier stage: one product a cycle while mac_en is set, registered.
    always_ff @(posedge clk)
    begin
        if (ctrl.mac_en)
        begin
            prod_reg <= op_a * op_b;
        end
    end

    // Valid and first-term flags are registered alongside the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            first_d_reg  <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mac_en;
            first_d_reg  <= ctrl.mac_first;
        end
    end

    // Accumulator: the first term of a sum loads, the rest add.
    always_ff @(posedge clk)
    begin
        if (prod_vld_reg)
        begin
            if (first_d_reg)
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Round half up, add the offset in calibration, then saturate.
    always_comb
    begin
        if (ctrl.cal_mode)
        begin
            rnd_sum  = acc_reg + CAL_HALF;
            shifted  = rnd_sum >>> acb_iir_pkg::CAL_SHIFT;
            with_off = shifted + ACC_W'(offset);
        end
        else
        begin
            rnd_sum  = acc_reg + FLT_HALF;
            shifted  = rnd_sum >>> acb_iir_pkg::FLT_SHIFT;
            with_off = shifted;
        end

        if (with_off > SAT_HI)
        begin
            result = acb_iir_pkg::VAL_MAX;
        end
        else if (with_off < SAT_LO)
        begin
            result = acb_iir_pkg::VAL_MIN;
        end
        else
        begin
            result = with_off[acb_iir_pkg::VAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/acb_iir_seq.sv]
`default_nettype none

module acb_iir_seq #(
    parameter int BLOCK_LEN = 4,
    parameter int CNT_W     = $clog2(BLOCK_LEN + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    out_free,
    output acb_iir_pkg::acb_ctrl_t       ctrl,
    output logic      [CNT_W-1:0]        slot,
    output logic      [CNT_W-1:0]        step
);

    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(BLOCK_LEN - 1);

    acb_iir_pkg::acb_state_t state_reg, state_next;
    logic [2:0]       term_reg,  term_next;
    logic [1:0]       axis_reg,  axis_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg,  step_next;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acb_iir_pkg::ST_IDLE;
            term_reg  <= '0;
            axis_reg  <= acb_iir_pkg::AXIS_X;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            axis_reg  <= axis_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    // Next state and counter updates.
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        axis_next  = axis_reg;
        count_next = count_reg;
        step_next  = step_reg;
        case (state_reg)
            acb_iir_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = acb_iir_pkg::ST_CAL_MAC;
                    term_next  = '0;
                    axis_next  = acb_iir_pkg::AXIS_X;
                end
            end
            acb_iir_pkg::ST_CAL_MAC:
            begin
                if (term_reg == acb_iir_pkg::CAL_LAST_TERM)
                begin
                    term_next  = '0;
                    state_next = acb_iir_pkg::ST_CAL_DRAIN;
                end
                else
                begin
                    term_next = term_reg + 3'd1;
                end
            end
            acb_iir_pkg::ST_CAL_DRAIN:
            begin
                state_next = acb_iir_pkg::ST_CAL_SAT;
            end
            acb_iir_pkg::ST_CAL_SAT:
            begin
                if (axis_reg == acb_iir_pkg::AXIS_Z)
                begin
                    axis_next = acb_iir_pkg::AXIS_X;
                    if (count_reg == LAST_SLOT)
                    begin
                        count_next = '0;
                        step_next  = '0;
                        state_next = acb_iir_pkg::ST_FLT_READ;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        state_next = acb_iir_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = acb_iir_pkg::ST_CAL_MAC;
                end
            end
            acb_iir_pkg::ST_FLT_READ:
            begin
                term_next  = '0;
                state_next = acb_iir_pkg::ST_FLT_MAC;
            end
            acb_iir_pkg::ST_FLT_MAC:
            begin
                if (term_reg == acb_iir_pkg::FLT_LAST_TERM)
                begin
                    term_next  = '0;
                    state_next = acb_iir_pkg::ST_FLT_DRAIN;
                end
                else
                begin
                    term_next = term_reg + 3'd1;
                end
            end
            acb_iir_pkg::ST_FLT_DRAIN:
            begin
                state_next = acb_iir_pkg::ST_FLT_SAT;
            end
            acb_iir_pkg::ST_FLT_SAT:
            begin
                if (step_reg == LAST_SLOT)
                begin
                    step_next = '0;
                    if (axis_reg == acb_iir_pkg::AXIS_Z)
                    begin
                        axis_next  = acb_iir_pkg::AXIS_X;
                        state_next = acb_iir_pkg::ST_EMIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = acb_iir_pkg::ST_FLT_READ;
                    end
                end
                else
                begin
                    step_next  = step_reg + CNT_W'(1);
                    state_next = acb_iir_pkg::ST_FLT_READ;
                end
            end
            acb_iir_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = acb_iir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = acb_iir_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs decoded from the state.
    always_comb
    begin
        ctrl      = '0;
        ctrl.axis = axis_reg;
        ctrl.term = term_reg;
        in_ready  = 1'b0;
        case (state_reg)
            acb_iir_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            acb_iir_pkg::ST_CAL_MAC:
            begin
                ctrl.cal_mode  = 1'b1;
                ctrl.mac_en    = 1'b1;
                ctrl.mac_first = (term_reg == acb_iir_pkg::TRM_RAW_X);
            end
            acb_iir_pkg::ST_CAL_DRAIN:
            begin
                ctrl.cal_mode = 1'b1;
            end
            acb_iir_pkg::ST_CAL_SAT:
            begin
                ctrl.cal_mode  = 1'b1;
                ctrl.cal_write = 1'b1;
            end
            acb_iir_pkg::ST_FLT_READ:
            begin
                ctrl.flt_read  = 1'b1;
                ctrl.flt_first = (step_reg == '0);
            end
            acb_iir_pkg::ST_FLT_MAC:
            begin
                ctrl.mac_en    = 1'b1;
                ctrl.mac_first = (term_reg == acb_iir_pkg::TRM_X0);
            end
            acb_iir_pkg::ST_FLT_DRAIN:
            begin
                ctrl.mac_en = 1'b0;
            end
            acb_iir_pkg::ST_FLT_SAT:
            begin
                ctrl.flt_update = 1'b1;
                ctrl.flt_last   = (step_reg == LAST_SLOT);
            end
            acb_iir_pkg::ST_EMIT:
            begin
                ctrl.emit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign slot = count_reg;
    assign step = step_reg;

    // A calibrated value is only ever written to a slot inside the block.
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cal_write |-> (count_reg <= LAST_SLOT))
        else $error("store slot beyond block length");

    // Once a word is taken, the block is busy with it on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again while a sample is in work");

    // The first filter product must use a store read issued just before.
    a_read_before_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acb_iir_pkg::ST_FLT_MAC && term_reg == acb_iir_pkg::TRM_X0)
        |-> ($past(state_reg) == acb_iir_pkg::ST_FLT_READ))
        else $error("filter product started without a fresh store read");

endmodule

`default_nettype wire

[hw/rtl/accel_calibrate_block_iir_unit.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_ready    raw_x, raw_y, raw_z
// out       out        out_valid / out_ready  filtered_x, filtered_y, filtered_z
//
// After acceptance the block calibrates the three axes in turn, each with three products,
// a drain and a saturate, and only then returns to idle to take the next word. The sample
// that completes a block adds, for each step of each axis, a store read, five products, a
// drain and a saturate, and then an emit state that hands the word to the output register.
// Reset is asynchronous; the sample store is not cleared and needs no pass.
// A finished word waits in its register; only a following block result waits for out_ready.

module accel_calibrate_block_iir_unit #(
    parameter int BLOCK_LEN   = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         cfg_valid,
    output logic                                              cfg_ready,
    input  wire logic        [acb_iir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic        [acb_iir_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                                         in_valid,
    output logic                                              in_ready,
    input  wire logic signed [acb_iir_pkg::RAW_W-1:0]         raw_x,
    input  wire logic signed [acb_iir_pkg::RAW_W-1:0]         raw_y,
    input  wire logic signed [acb_iir_pkg::RAW_W-1:0]         raw_z,
    output logic                                              out_valid,
    input  wire logic                                         out_ready,
    output logic      signed [acb_iir_pkg::VAL_W-1:0]         filtered_x,
    output logic      signed [acb_iir_pkg::VAL_W-1:0]         filtered_y,
    output logic      signed [acb_iir_pkg::VAL_W-1:0]         filtered_z
);

    localparam int CNT_W     = $clog2(BLOCK_LEN + 1);
    localparam int MEM_DEPTH = 3 * BLOCK_LEN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int OPA_W     = acb_iir_pkg::OPA_W;
    localparam int VAL_W     = acb_iir_pkg::VAL_W;
    localparam int DATA_W    = acb_iir_pkg::CFG_DATA_W;

    // Sign extension of a raw reading taken as SAMPLE_BITS wide.
    function automatic logic signed [OPA_W-1:0] sext_sample(
        input logic [acb_iir_pkg::RAW_W-1:0] raw
    );
        logic [OPA_W-1:0] ext;
        logic [OPA_W-1:0] res;
        ext = OPA_W'(raw);
        for (int b = 0; b < OPA_W; b++)
        begin
            res[b] = (b < SAMPLE_BITS) ? ext[b] : ext[SAMPLE_BITS-1];
        end
        return res;
    endfunction

    // One signed 16-bit field out of a packed register.
    function automatic logic signed [acb_iir_pkg::FIELD_W-1:0] field16(
        input logic [DATA_W-1:0] r,
        input logic [1:0]        idx
    );
        logic signed [acb_iir_pkg::FIELD_W-1:0] f;
        case (idx)
            2'd0:    f = r[15:0];
            2'd1:    f = r[31:16];
            default: f = r[47:32];
        endcase
        return f;
    endfunction

    logic [DATA_W-1:0]                cal_col_x_reg;
    logic [DATA_W-1:0]                cal_col_y_reg;
    logic [DATA_W-1:0]                cal_col_z_reg;
    logic [DATA_W-1:0]                cal_offsets_reg;
    logic [DATA_W-1:0]                ff_coeffs_reg;
    logic [acb_iir_pkg::FB_W-1:0]     fb_coeffs_reg;

    logic signed [OPA_W-1:0]          samp_x_reg;
    logic signed [OPA_W-1:0]          samp_y_reg;
    logic signed [OPA_W-1:0]          samp_z_reg;

    logic signed [VAL_W-1:0]          x1_reg;
    logic signed [VAL_W-1:0]          x2_reg;
    logic signed [VAL_W-1:0]          y1_reg;
    logic signed [VAL_W-1:0]          y2_reg;
    logic signed [VAL_W-1:0]          res_x_reg;
    logic signed [VAL_W-1:0]          res_y_reg;
    logic signed [VAL_W-1:0]          res_z_reg;

    logic signed [VAL_W-1:0]          filtered_x_reg;
    logic signed [VAL_W-1:0]          filtered_y_reg;
    logic signed [VAL_W-1:0]          filtered_z_reg;
    logic                             out_valid_reg, out_valid_next;

    acb_iir_pkg::acb_ctrl_t           ctrl;
    logic [CNT_W-1:0]                 slot;
    logic [CNT_W-1:0]                 step;
    logic                             out_free;

    logic [ADDR_W-1:0]                axis_base;
    logic [ADDR_W-1:0]                wr_addr;
    logic [ADDR_W-1:0]                rd_addr;
    logic [VAL_W-1:0]                 rd_data;
    logic signed [VAL_W-1:0]          x0;

    logic [DATA_W-1:0]                col_sel;
    logic signed [OPA_W-1:0]          op_a;
    logic signed [acb_iir_pkg::OPB_W-1:0] op_b;
    logic signed [VAL_W-1:0]          offset;
    logic signed [VAL_W-1:0]          mac_result;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_col_x_reg   <= acb_iir_pkg::RST_CAL_COL_X;
            cal_col_y_reg   <= acb_iir_pkg::RST_CAL_COL_Y;
            cal_col_z_reg   <= acb_iir_pkg::RST_CAL_COL_Z;
            cal_offsets_reg <= acb_iir_pkg::RST_CAL_OFFSETS;
            ff_coeffs_reg   <= acb_iir_pkg::RST_FF_COEFFS;
            fb_coeffs_reg   <= acb_iir_pkg::RST_FB_COEFFS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                acb_iir_pkg::CFG_CAL_COL_X:   cal_col_x_reg   <= cfg_data;
                acb_iir_pkg::CFG_CAL_COL_Y:   cal_col_y_reg   <= cfg_data;
                acb_iir_pkg::CFG_CAL_COL_Z:   cal_col_z_reg   <= cfg_data;
                acb_iir_pkg::CFG_CAL_OFFSETS: cal_offsets_reg <= cfg_data;
                acb_iir_pkg::CFG_FF_COEFFS:   ff_coeffs_reg   <= cfg_data;
                acb_iir_pkg::CFG_FB_COEFFS:
                begin
                    fb_coeffs_reg <= cfg_data[acb_iir_pkg::FB_W-1:0];
                end
                default:
                begin
                    fb_coeffs_reg <= fb_coeffs_reg;
                end
            endcase
        end
    end

    // Sequencer.
    acb_iir_seq #(
        .BLOCK_LEN (BLOCK_LEN),
        .CNT_W     (CNT_W)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .ctrl     (ctrl),
        .slot     (slot),
        .step     (step)
    );

    // Capture the incoming sample.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            samp_x_reg <= sext_sample(raw_x);
            samp_y_reg <= sext_sample(raw_y);
            samp_z_reg <= sext_sample(raw_z);
        end
    end

    // Sample store: one region of BLOCK_LEN entries per axis.
    assign axis_base = ADDR_W'(ctrl.axis) * ADDR_W'(BLOCK_LEN);
    assign wr_addr   = axis_base + ADDR_W'(slot);
    assign rd_addr   = axis_base + ADDR_W'(step);

    acb_iir_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ctrl.cal_write),
        .wr_addr (wr_addr),
        .wr_data (mac_result),
        .rd_en   (ctrl.flt_read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign x0 = rd_data;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (ctrl.axis)
            acb_iir_pkg::AXIS_X: col_sel = cal_col_x_reg;
            acb_iir_pkg::AXIS_Y: col_sel = cal_col_y_reg;
            default:             col_sel = cal_col_z_reg;
        endcase

        offset = VAL_W'(field16(cal_offsets_reg, ctrl.axis));

        if (ctrl.cal_mode)
        begin
            op_b = field16(col_sel, ctrl.term[1:0]);
            case (ctrl.term)
                acb_iir_pkg::TRM_RAW_X: op_a = samp_x_reg;
                acb_iir_pkg::TRM_RAW_Y: op_a = samp_y_reg;
                default:                op_a = samp_z_reg;
            endcase
        end
        else
        begin
            case (ctrl.term)
                acb_iir_pkg::TRM_X0:
                begin
                    op_a = OPA_W'(x0);
                    op_b = field16(ff_coeffs_reg, 2'd0);
                end
                acb_iir_pkg::TRM_X1:
                begin
                    op_a = OPA_W'(x1_reg);
                    op_b = field16(ff_coeffs_reg, 2'd1);
                end
                acb_iir_pkg::TRM_X2:
                begin
                    op_a = OPA_W'(x2_reg);
                    op_b = field16(ff_coeffs_reg, 2'd2);
                end
                acb_iir_pkg::TRM_Y1:
                begin
                    op_a = OPA_W'(y1_reg);
                    op_b = field16(DATA_W'(fb_coeffs_reg), 2'd0);
                end
                default:
                begin
                    op_a = OPA_W'(y2_reg);
                    op_b = field16(DATA_W'(fb_coeffs_reg), 2'd1);
                end
            endcase
        end
    end

    // Shared multiply-accumulate, rounding and saturation unit.
    acb_iir_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .op_a   (op_a),
        .op_b   (op_b),
        .offset (offset),
        .result (mac_result)
    );

    // Filter history: cleared at the start of each axis, shifted each step.
    always_ff @(posedge clk)
    begin
        if (ctrl.flt_read && ctrl.flt_first)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (ctrl.flt_update)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x0;
            y2_reg <= y1_reg;
            y1_reg <= mac_result;
        end
    end

    // Last filtered value of each axis.
    always_ff @(posedge clk)
    begin
        if (ctrl.flt_update && ctrl.flt_last)
        begin
            case (ctrl.axis)
                acb_iir_pkg::AXIS_X: res_x_reg <= mac_result;
                acb_iir_pkg::AXIS_Y: res_y_reg <= mac_result;
                default:             res_z_reg <= mac_result;
            endcase
        end
    end

    // Output register and its valid flag.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            filtered_x_reg <= res_x_reg;
            filtered_y_reg <= res_y_reg;
            filtered_z_reg <= res_z_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign filtered_x = filtered_x_reg;
    assign filtered_y = filtered_y_reg;
    assign filtered_z = filtered_z_reg;

endmodule

`default_nettype wire

[test/tb_accel_calibrate_block_iir_unit.sv]
module tb_accel_calibrate_block_iir_unit;
    import acb_iir_pkg::*;

    localparam int BLOCK_LEN = 4;
    localparam int NUM_REGS  = 6;
    localparam int QUIET_CYCLES = 64;

    // Register indexes past the last real register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam logic signed [RAW_W-1:0] RAW_HI = 16'sh7FFF;
    localparam logic signed [RAW_W-1:0] RAW_LO = 16'sh8000;

    typedef struct {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } filtered_word_t;

    // Scoreboard: calibrates each accepted sample, filters every full block and
    // holds the filtered words still owed by the block.
    class filtered_word_board;
        logic [CFG_DATA_W-1:0]   regs [NUM_REGS];
        logic signed [VAL_W-1:0] cal_store [3][BLOCK_LEN];
        int unsigned             fill;
        filtered_word_t          pending_words [$];
        int                      errors;
        int                      samples;
        int                      words;

        function new();
            regs[CFG_CAL_COL_X]   = RST_CAL_COL_X;
            regs[CFG_CAL_COL_Y]   = RST_CAL_COL_Y;
            regs[CFG_CAL_COL_Z]   = RST_CAL_COL_Z;
            regs[CFG_CAL_OFFSETS] = RST_CAL_OFFSETS;
            regs[CFG_FF_COEFFS]   = RST_FF_COEFFS;
            regs[CFG_FB_COEFFS]   = {16'd0, RST_FB_COEFFS};
            fill = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CAL_COL_X, CFG_CAL_COL_Y, CFG_CAL_COL_Z, CFG_CAL_OFFSETS, CFG_FF_COEFFS:
                    regs[idx] = data;
                CFG_FB_COEFFS:
                    regs[idx] = {16'd0, data[FB_W-1:0]};
                default:
                    ;
            endcase
        endfunction

        static function longint lane(logic [CFG_DATA_W-1:0] r, int k);
            return longint'($signed(r[FIELD_W*k +: FIELD_W]));
        endfunction

        static function logic signed [VAL_W-1:0] clamp(longint v);
            if (v > VAL_MAX)
                return VAL_MAX;
            if (v < VAL_MIN)
                return VAL_MIN;
            return v[VAL_W-1:0];
        endfunction

        // Gain row times raw vector, rounded half up to 2^-12 g, plus offset.
        function logic signed [VAL_W-1:0] calibrate(int axis, longint rx, longint ry,
                                                    longint rz);
            logic [CFG_DATA_W-1:0] row;
            longint                acc;
            row = regs[int'(CFG_CAL_COL_X) + axis];
            acc = rx * lane(row, 0) + ry * lane(row, 1) + rz * lane(row, 2);
            acc = (acc + (longint'(1) <<< (CAL_SHIFT - 1))) >>> CAL_SHIFT;
            return clamp(acc + lane(regs[CFG_CAL_OFFSETS], axis));
        endfunction

        // Biquad over one stored block from zero history; feedback terms are added.
        function logic signed [VAL_W-1:0] biquad(int axis);
            longint                  b0, b1, b2, a1, a2;
            longint                  x0, x1, x2, y1, y2, acc;
            logic signed [VAL_W-1:0] yv;
            b0 = lane(regs[CFG_FF_COEFFS], 0);
            b1 = lane(regs[CFG_FF_COEFFS], 1);
            b2 = lane(regs[CFG_FF_COEFFS], 2);
            a1 = lane(regs[CFG_FB_COEFFS], 0);
            a2 = lane(regs[CFG_FB_COEFFS], 1);
            x1 = 0;
            x2 = 0;
            y1 = 0;
            y2 = 0;
            yv = '0;
            for (int i = 0; i < BLOCK_LEN; i++)
            begin
                x0  = cal_store[axis][i];
                acc = b0 * x0 + b1 * x1 + b2 * x2 + a1 * y1 + a2 * y2;
                yv  = clamp((acc + (longint'(1) <<< (FLT_SHIFT - 1))) >>> FLT_SHIFT);
                x2  = x1;
                x1  = x0;
                y2  = y1;
                y1  = yv;
            end
            return yv;
        endfunction

        function void take_sample(logic signed [RAW_W-1:0] rx, logic signed [RAW_W-1:0] ry,
                                  logic signed [RAW_W-1:0] rz);
            filtered_word_t w;
            for (int axis = 0; axis < 3; axis++)
                cal_store[axis][fill] = calibrate(axis, rx, ry, rz);
            fill++;
            samples++;
            if (fill == BLOCK_LEN)
            begin
                w.x = biquad(AXIS_X);
                w.y = biquad(AXIS_Y);
                w.z = biquad(AXIS_Z);
                pending_words.push_back(w);
                fill = 0;
            end
        endfunction

        function void compare(string name, logic signed [VAL_W-1:0] want,
                              logic signed [VAL_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic signed [VAL_W-1:0] fx, logic signed [VAL_W-1:0] fy,
                                 logic signed [VAL_W-1:0] fz);
            filtered_word_t w;
            if (pending_words.size() == 0)
            begin
                $error("filtered word x=%0d y=%0d z=%0d with none expected", fx, fy, fz);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            words++;
            compare("filtered_x", w.x, fx);
            compare("filtered_y", w.y, fy);
            compare("filtered_z", w.z, fz);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [RAW_W-1:0]       raw_x;
    logic signed [RAW_W-1:0]       raw_y;
    logic signed [RAW_W-1:0]       raw_z;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [VAL_W-1:0]       filtered_x;
    logic signed [VAL_W-1:0]       filtered_y;
    logic signed [VAL_W-1:0]       filtered_z;

    filtered_word_board    board;
    logic [CFG_DATA_W-1:0] setting [NUM_REGS];
    bit                    calm;
    int                    settings_applied;

    accel_calibrate_block_iir_unit #(
        .BLOCK_LEN   (BLOCK_LEN),
        .SAMPLE_BITS (RAW_W)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_x      (raw_x),
        .raw_y      (raw_y),
        .raw_z      (raw_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .filtered_x (filtered_x),
        .filtered_y (filtered_y),
        .filtered_z (filtered_z)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: check each accepted word and stall at random outside calm stretches.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_word(filtered_x, filtered_y, filtered_z);
        out_ready <= calm || ($urandom_range(99) >= 28);
    end

    initial
    begin
        #500000;
        $display("tb_accel_calibrate_block_iir_unit NOT OK");
        $finish;
    end

    // Present one sample and hold it until the block takes the word.
    task automatic send_sample(input logic signed [RAW_W-1:0] sx,
                               input logic signed [RAW_W-1:0] sy,
                               input logic signed [RAW_W-1:0] sz);
        int gap;
        gap = 0;
        if (!calm)
        begin
            if ($urandom_range(99) < 3)
                gap = $urandom_range(40, 1);
            while ($urandom_range(99) < 28)
                gap++;
        end
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_x    <= sx;
        raw_y    <= sy;
        raw_z    <= sz;
        do
            @(posedge clk);
        while (!in_ready);
        board.take_sample(sx, sy, sz);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    // Write all six registers from the setting array, then the two spare indexes.
    task automatic apply_setting();
        put_reg(CFG_CAL_COL_X, setting[CFG_CAL_COL_X]);
        put_reg(CFG_CAL_COL_Y, setting[CFG_CAL_COL_Y]);
        put_reg(CFG_CAL_COL_Z, setting[CFG_CAL_COL_Z]);
        put_reg(CFG_CAL_OFFSETS, setting[CFG_CAL_OFFSETS]);
        put_reg(CFG_FF_COEFFS, setting[CFG_FF_COEFFS]);
        put_reg(CFG_FB_COEFFS, setting[CFG_FB_COEFFS]);
        put_reg(CFG_SPARE_6, {16'($urandom), 32'($urandom)});
        put_reg(CFG_SPARE_7, {16'($urandom), 32'($urandom)});
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // Stop sending, let every owed word arrive and the last sample finish.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_words.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic void fill_setting(logic [CFG_DATA_W-1:0] v);
        for (int k = 0; k < NUM_REGS; k++)
            setting[k] = v;
    endfunction

    // Three 16-bit lanes, each within +/-span, or fully random when span is zero.
    function automatic logic [CFG_DATA_W-1:0] rand_lanes(int span);
        logic [CFG_DATA_W-1:0] v;
        v = {16'($urandom), 32'($urandom)};
        if (span > 0)
            for (int k = 0; k < 3; k++)
                v[FIELD_W*k +: FIELD_W] = 16'(int'($urandom_range(2 * span)) - span);
        return v;
    endfunction

    function automatic logic signed [RAW_W-1:0] pick_raw();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return RAW_HI;
        if (r < 10)
            return RAW_LO;
        if (r < 13)
            return '0;
        return RAW_W'($urandom);
    endfunction

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        raw_x     = '0;
        raw_y     = '0;
        raw_z     = '0;
        out_ready = 1'b0;
        calm      = 1'b0;
        settings_applied = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset: field extremes and alternating bit patterns.
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(RAW_HI, RAW_HI, RAW_HI);
        send_sample(RAW_LO, RAW_LO, RAW_LO);
        send_sample(RAW_HI, RAW_LO, 16'sd0);
        send_sample(RAW_LO, RAW_HI, -16'sd1);
        send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
        send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
        send_sample(16'sd1, -16'sd1, 16'sd1);
        wait_quiet();

        // Largest positive gains and coefficients drive both stages into saturation.
        fill_setting(48'h7FFF_7FFF_7FFF);
        apply_setting();
        repeat (4) send_sample(RAW_HI, RAW_HI, RAW_HI);
        repeat (4) send_sample(RAW_LO, RAW_LO, RAW_LO);
        wait_quiet();

        // Most negative gains and coefficients.
        fill_setting(48'h8000_8000_8000);
        apply_setting();
        send_sample(RAW_HI, RAW_LO, RAW_HI);
        send_sample(RAW_LO, RAW_LO, RAW_LO);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(RAW_HI, RAW_HI, RAW_HI);
        wait_quiet();

        // All registers cleared.
        fill_setting('0);
        apply_setting();
        send_sample(RAW_HI, RAW_LO, 16'sd1);
        send_sample(RAW_LO, RAW_HI, -16'sd1);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(RAW_HI, RAW_HI, RAW_HI);
        wait_quiet();

        // Random phases: each mixes plausible and fully random register values.
        for (int ph = 0; ph < 5; ph++)
        begin
            setting[CFG_CAL_COL_X]   = rand_lanes($urandom_range(1) ? 0 : 8192);
            setting[CFG_CAL_COL_Y]   = rand_lanes($urandom_range(1) ? 0 : 8192);
            setting[CFG_CAL_COL_Z]   = rand_lanes($urandom_range(1) ? 0 : 8192);
            setting[CFG_CAL_OFFSETS] = rand_lanes($urandom_range(1) ? 0 : 2048);
            setting[CFG_FF_COEFFS]   = rand_lanes($urandom_range(99) < 40 ? 0 : 16384);
            setting[CFG_FB_COEFFS]   = rand_lanes($urandom_range(99) < 40 ? 0 : 8000);
            apply_setting();
            calm = (ph == 3);
            for (int n = 0; n < 110; n++)
            begin
                // Once, hold the input back until every owed word has been taken.
                if (ph == 1 && n == 50)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (board.pending_words.size() != 0)
                        @(posedge clk);
                end
                send_sample(pick_raw(), pick_raw(), pick_raw());
            end
            wait_quiet();
            calm = 1'b0;
        end

        $display("Run covered %0d samples and %0d filtered words over %0d register settings,",
                 board.samples, board.words, settings_applied + 1);
        $display("including saturated values, ignored spare indexes and a calm stretch.");
        if (board.errors == 0)
            $display("tb_accel_calibrate_block_iir_unit OK");
        else
            $display("tb_accel_calibrate_block_iir_unit NOT OK");
        $finish;
    end
endmodule
